>>> sv/isort_pkg.sv
// Shared types and constants for the integer sorter.
// No dependencies; every other file imports this package.
package isort_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CAPACITY   = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DRN_W      = $clog2(CAPACITY);

  localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(CAPACITY);
  localparam logic [DRN_W-1:0] DRAIN_INIT = DRN_W'(CAPACITY - 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Control handed from the controller to every cell of the chain.
  typedef struct packed {
    logic shift;
  } cell_ctl_t;

endpackage

>>> sv/isort_cell.sv
// One cell of the insertion chain: holds one element, keeps the smaller of
// its element and the arriving one, and passes the larger to the next cell.
// Depends on isort_pkg.
module isort_cell
  import isort_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      pin_valid,
  input  data_t     pin_data,
  input  logic      nbr_valid,
  input  data_t     nbr_data,
  output logic      pout_valid,
  output data_t     pout_data,
  output logic      held_valid,
  output data_t     held_data
);

  logic  held_valid_r, held_valid_nxt;
  data_t held_data_r, held_data_nxt;
  logic  pass_valid_r, pass_valid_nxt;
  data_t pass_data_r, pass_data_nxt;

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_data_nxt  = held_data_r;
    pass_valid_nxt = 1'b0;
    pass_data_nxt  = pin_data;
    if (ctl.shift) begin
      // Output phase: the chain moves one place toward the head.
      held_valid_nxt = nbr_valid;
      held_data_nxt  = nbr_data;
    end else if (pin_valid) begin
      if (!held_valid_r) begin
        held_valid_nxt = 1'b1;
        held_data_nxt  = pin_data;
      end else if (pin_data < held_data_r) begin
        held_data_nxt  = pin_data;
        pass_valid_nxt = 1'b1;
        pass_data_nxt  = held_data_r;
      end else begin
        pass_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      pass_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      pass_valid_r <= pass_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_data_r <= held_data_nxt;
    pass_data_r <= pass_data_nxt;
  end

  assign pout_valid = pass_valid_r;
  assign pout_data  = pass_data_r;
  assign held_valid = held_valid_r;
  assign held_data  = held_data_r;

endmodule

>>> sv/isort_ctrl.sv
// Run controller: counts stored elements, tracks overflow, waits for the
// chain to settle and then unloads it through the output registers.
// Depends on isort_pkg.
module isort_ctrl
  import isort_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_last,
  input  data_t     head_data,
  output logic      busy,
  output logic      inject,
  output cell_ctl_t ctl,
  output logic      out_valid,
  output data_t     out_sorted_value,
  output logic      out_final_res,
  output logic      out_overflow
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [DRN_W-1:0] drain_r, drain_nxt;
  logic             ov_r, ov_nxt;
  data_t            val_r, val_nxt;
  logic             fin_r, fin_nxt;
  logic             ovo_r, ovo_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    drain_nxt = drain_r;
    ov_nxt    = 1'b0;
    val_nxt   = head_data;
    fin_nxt   = 1'b0;
    ovo_nxt   = ovf_r;
    busy      = 1'b1;
    inject    = 1'b0;
    ctl.shift = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (cnt_r < CAP_CNT) begin
            inject  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_DRAIN;
            drain_nxt = DRAIN_INIT;
          end
        end
      end
      ST_DRAIN: begin
        // The last element moves on one cell per cycle until it reaches its place.
        drain_nxt = drain_r - DRN_W'(1);
        if (drain_r == DRN_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctl.shift = 1'b1;
        ov_nxt    = 1'b1;
        fin_nxt   = (cnt_r == CNT_W'(1));
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      drain_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      drain_r <= drain_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    fin_r <= fin_nxt;
    ovo_r <= ovo_nxt;
  end

  assign out_valid        = ov_r;
  assign out_sorted_value = val_r;
  assign out_final_res    = fin_r;
  assign out_overflow     = ovo_r;

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r != '0)
    else $error("unload phase entered with no stored elements");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("element count exceeds capacity");

  a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result transfer followed the final result");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last |=> state_r == ST_DRAIN && !ovf_r == !$past(ovf_nxt))
    else $error("last element did not start the settle phase");

endmodule

>>> sv/integer_sorter_top.sv
// Integer sorter top level: a chain of insertion cells and its controller.
// Depends on isort_pkg, isort_cell and isort_ctrl.
//
// Elements load one per cycle while busy is low; each enters the cell chain
// and settles one cell per cycle, the chain staying in ascending order. The
// item marked last makes busy rise: the chain then settles, for a time set
// by its length, after which the run is unloaded from the head of the
// chain, one result per cycle on out_valid, smallest first, the greatest
// flagged by out_final_res. A run of n stored elements keeps busy high
// through settling and unloading. Results cannot be held off by the
// receiver. Elements beyond CAPACITY are dropped and every result of that
// run carries out_overflow.
module integer_sorter_top
  import isort_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  data_t in_value,
  input  logic  in_last,
  output logic  out_valid,
  output data_t out_sorted_value,
  output logic  out_final_res,
  output logic  out_overflow
);

  cell_ctl_t ctl;
  logic      inject;
  logic      pv [CAPACITY+1];
  data_t     pd [CAPACITY+1];
  logic      hv [CAPACITY];
  data_t     hd [CAPACITY];

  assign pv[0] = inject;
  assign pd[0] = in_value;

  isort_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_last          (in_last),
    .head_data        (hd[0]),
    .busy             (busy),
    .inject           (inject),
    .ctl              (ctl),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  nv;
    data_t nd;
    if (i == CAPACITY - 1) begin : g_tail
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_mid
      assign nv = hv[i+1];
      assign nd = hd[i+1];
    end
    isort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .pin_valid  (pv[i]),
      .pin_data   (pd[i]),
      .nbr_valid  (nv),
      .nbr_data   (nd),
      .pout_valid (pv[i+1]),
      .pout_data  (pd[i+1]),
      .held_valid (hv[i]),
      .held_data  (hd[i])
    );
  end

endmodule
